// ----- design/jgas_pkg.sv -----
// ---------------------------------------------------------------------------
// jgas_pkg
// Shared types, constants and arithmetic helpers of the gimbal attitude
// shaper: datapath operation codes, register indexes, command and status.
// ---------------------------------------------------------------------------
package jgas_pkg;

  localparam int MW           = 33;  // multiplier operand width
  localparam int PW           = 66;  // multiplier product width
  localparam int CW           = 32;  // CORDIC x/y width, Q2.30
  localparam int ZW           = 26;  // CORDIC angle width, 2^-16 degree
  localparam int IW           = 5;   // step index width
  localparam int CORDIC_STEPS = 18;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_PREP,
    OP_DIV,
    OP_Y,
    OP_M_YY,
    OP_X2,
    OP_M_X2Y,
    OP_X3,
    OP_M_EY,
    OP_ACC,
    OP_M_EX3,
    OP_SHAPE,
    OP_RUN,
    OP_M_AIN,
    OP_M_AS,
    OP_SMOOTH,
    OP_STOP,
    OP_M_LIM,
    OP_ANGLE,
    OP_M_LIM100,
    OP_CENT,
    OP_CINIT,
    OP_CSTEP,
    OP_M_QUAT,
    OP_QUAT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_DEAD_BAND   = 3'd1,
    REG_EXPO_MIX    = 3'd2,
    REG_SMOOTH_GAIN = 3'd3,
    REG_PITCH_LIMIT = 3'd4,
    REG_YAW_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    op_t           op;
    logic          ax;    // 0 pitch, 1 yaw
    logic [IW-1:0] idx;   // divide / CORDIC step, quaternion component
    logic          stop;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic running;
    logic active;
    logic out_free;
  } stat_t;

  // arctangent of 2^-i in 2^-16 degree
  function automatic logic [21:0] atan_val(input logic [IW-1:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // right shift, rounding half away from zero
  function automatic logic signed [PW-1:0] rnd_shr(input logic signed [PW-1:0] v,
                                                   input int s);
    logic [PW-1:0] mg;
    logic [PW-1:0] half;
    half = {{(PW-1){1'b0}}, 1'b1} << (s - 1);
    mg   = v[PW-1] ? -v : v;
    mg   = (mg + half) >> s;
    return v[PW-1] ? -$signed(mg) : $signed(mg);
  endfunction

endpackage

// ----- design/joystick_gimbal_attitude_shaper_unit.sv -----
// ---------------------------------------------------------------------------
// joystick_gimbal_attitude_shaper_unit
// Stick pitch/yaw to gimbal attitude: deadband, expo, low-pass filter,
// centidegree angles and roll-zero quaternion.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): cmd 0 carries a stick sample, cmd 1 a
//   send tick. One transaction is processed at a time; in_stall stays high
//   while an item is worked on.
//   Sample: deadband through the bit-serial divider, one quotient bit a cycle
//   per axis. Samples while disabled are dropped.
//   Tick: processed by the 18-step CORDIC and the single shared multiplier,
//   or ended early in a stop result. Ticks while not running give no result.
//   Output channel (out_valid/out_stall): one result register. A new item is
//   accepted while a result waits; a finished result is held until the
//   register frees, stalling further input meanwhile.
//   Configuration (cfg_valid/cfg_ready): always ready; write only when idle.
//   Reset: registers take their defaults, state clears, nothing pending.
// ---------------------------------------------------------------------------
module joystick_gimbal_attitude_shaper_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [15:0] pitch_axis,
  input  logic signed [15:0] yaw_axis,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [15:0] pitch_centideg,
  output logic signed [15:0] yaw_centideg,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  import jgas_pkg::*;

  cmd_t  dp_cmd;
  stat_t dp_stat;

  assign cfg_ready = 1'b1;

  jgas_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  jgas_dp #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pitch_axis     (pitch_axis),
    .yaw_axis       (yaw_axis),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .pitch_centideg (pitch_centideg),
    .yaw_centideg   (yaw_centideg),
    .quat_w         (quat_w),
    .quat_x         (quat_x),
    .quat_y         (quat_y),
    .quat_z         (quat_z)
  );

endmodule

// ----- design/jgas_ctrl.sv -----
// ---------------------------------------------------------------------------
// jgas_ctrl
// Sequencer of the shaper: accepts items, steps the datapath through the
// deadband divide, expo, filter, angle, CORDIC and quaternion operations.
// ---------------------------------------------------------------------------
module jgas_ctrl #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           cmd,
  input  jgas_pkg::stat_t dp_stat,
  output jgas_pkg::cmd_t  dp_cmd
);
  import jgas_pkg::*;

  typedef enum logic [26:0] {
    ST_IDLE  = 27'd1 << 0,
    ST_PREP  = 27'd1 << 1,
    ST_DIV   = 27'd1 << 2,
    ST_Y     = 27'd1 << 3,
    ST_M1    = 27'd1 << 4,
    ST_X2    = 27'd1 << 5,
    ST_M2    = 27'd1 << 6,
    ST_X3    = 27'd1 << 7,
    ST_M3    = 27'd1 << 8,
    ST_ACC   = 27'd1 << 9,
    ST_M4    = 27'd1 << 10,
    ST_SH    = 27'd1 << 11,
    ST_RUN   = 27'd1 << 12,
    ST_TM1   = 27'd1 << 13,
    ST_TACC  = 27'd1 << 14,
    ST_TM2   = 27'd1 << 15,
    ST_TSM   = 27'd1 << 16,
    ST_CHK   = 27'd1 << 17,
    ST_LM    = 27'd1 << 18,
    ST_LZ    = 27'd1 << 19,
    ST_CM    = 27'd1 << 20,
    ST_CD    = 27'd1 << 21,
    ST_CINIT = 27'd1 << 22,
    ST_CSTEP = 27'd1 << 23,
    ST_QM    = 27'd1 << 24,
    ST_QS    = 27'd1 << 25,
    ST_DONE  = 27'd1 << 26
  } state_t;

  localparam logic [IW-1:0] DIV_LAST = IW'(SAMPLE_WIDTH - 1);
  localparam logic [IW-1:0] ROT_LAST = IW'(CORDIC_STEPS - 1);
  localparam logic [IW-1:0] QT_LAST  = IW'(3);

  state_t        state, state_next;
  logic          ax, ax_next;
  logic [IW-1:0] cnt, cnt_next;
  logic          stop, stop_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ax    <= 1'b0;
      cnt   <= '0;
      stop  <= 1'b0;
    end else begin
      state <= state_next;
      ax    <= ax_next;
      cnt   <= cnt_next;
      stop  <= stop_next;
    end
  end

  always_comb begin
    state_next  = state;
    ax_next     = ax;
    cnt_next    = cnt;
    stop_next   = stop;
    dp_cmd.op   = OP_IDLE;
    dp_cmd.ax   = ax;
    dp_cmd.idx  = cnt;
    dp_cmd.stop = stop;
    unique case (state)
      ST_IDLE: begin
        ax_next  = 1'b0;
        cnt_next = '0;
        if (in_valid) begin
          dp_cmd.op = OP_CAPTURE;
          // drop samples while disabled and ticks while stopped
          if (!cmd && dp_stat.enable) state_next = ST_PREP;
          else if (cmd && dp_stat.running) state_next = ST_TM1;
        end
      end
      ST_PREP: begin
        dp_cmd.op  = OP_PREP;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        dp_cmd.op = OP_DIV;
        if (cnt == DIV_LAST) state_next = ST_Y;
        else cnt_next = cnt + 1'b1;
      end
      ST_Y:   begin dp_cmd.op = OP_Y;     state_next = ST_M1;  end
      ST_M1:  begin dp_cmd.op = OP_M_YY;  state_next = ST_X2;  end
      ST_X2:  begin dp_cmd.op = OP_X2;    state_next = ST_M2;  end
      ST_M2:  begin dp_cmd.op = OP_M_X2Y; state_next = ST_X3;  end
      ST_X3:  begin dp_cmd.op = OP_X3;    state_next = ST_M3;  end
      ST_M3:  begin dp_cmd.op = OP_M_EY;  state_next = ST_ACC; end
      ST_ACC: begin dp_cmd.op = OP_ACC;   state_next = ST_M4;  end
      ST_M4:  begin dp_cmd.op = OP_M_EX3; state_next = ST_SH;  end
      ST_SH: begin
        dp_cmd.op = OP_SHAPE;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = ST_PREP;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin dp_cmd.op = OP_RUN;   state_next = ST_IDLE; end
      ST_TM1:  begin dp_cmd.op = OP_M_AIN; state_next = ST_TACC; end
      ST_TACC: begin dp_cmd.op = OP_ACC;   state_next = ST_TM2;  end
      ST_TM2:  begin dp_cmd.op = OP_M_AS;  state_next = ST_TSM;  end
      ST_TSM: begin
        dp_cmd.op = OP_SMOOTH;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = ST_TM1;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        ax_next = 1'b0;
        if (dp_stat.active) begin
          stop_next  = 1'b0;
          state_next = ST_LM;
        end else begin
          dp_cmd.op  = OP_STOP;
          stop_next  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_LM: begin dp_cmd.op = OP_M_LIM;    state_next = ST_LZ; end
      ST_LZ: begin dp_cmd.op = OP_ANGLE;    state_next = ST_CM; end
      ST_CM: begin dp_cmd.op = OP_M_LIM100; state_next = ST_CD; end
      ST_CD: begin
        dp_cmd.op = OP_CENT;
        if (!ax) begin
          ax_next    = 1'b1;
          state_next = ST_LM;
        end else begin
          state_next = ST_CINIT;
        end
      end
      ST_CINIT: begin
        dp_cmd.op  = OP_CINIT;
        cnt_next   = '0;
        state_next = ST_CSTEP;
      end
      ST_CSTEP: begin
        dp_cmd.op = OP_CSTEP;
        if (cnt == ROT_LAST) begin
          cnt_next   = '0;
          state_next = ST_QM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_QM: begin dp_cmd.op = OP_M_QUAT; state_next = ST_QS; end
      ST_QS: begin
        dp_cmd.op = OP_QUAT;
        if (cnt == QT_LAST) begin
          state_next = ST_DONE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_QM;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (dp_stat.out_free) begin
          dp_cmd.op  = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/jgas_dp.sv -----
// ---------------------------------------------------------------------------
// jgas_dp
// Datapath of the shaper: configuration registers, state, shared multiplier,
// restoring divider, two-lane CORDIC and the output register.
// ---------------------------------------------------------------------------
module jgas_dp #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  pitch_axis,
  input  logic signed [15:0]  yaw_axis,
  input  jgas_pkg::cmd_t      dp_cmd,
  output jgas_pkg::stat_t     dp_stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic signed [15:0]  pitch_centideg,
  output logic signed [15:0]  yaw_centideg,
  output logic signed [15:0]  quat_w,
  output logic signed [15:0]  quat_x,
  output logic signed [15:0]  quat_y,
  output logic signed [15:0]  quat_z
);
  import jgas_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int F      = SW - 1;
  localparam int ONE    = 1 << F;
  localparam int ACT    = ONE / 1000;
  localparam int YW     = SW + 1;
  localparam int AW     = SW + 18;
  localparam int NUMW   = 2 * SW - 1;
  localparam int SH_UP  = (F >= 15) ? F - 15 : 0;
  localparam int SH_DN  = (F < 15) ? 15 - F : 0;
  localparam logic signed [PW-1:0] SMAX = PW'(ONE - 1);
  localparam logic signed [PW-1:0] SMIN = -PW'(ONE);
  localparam logic signed [PW-1:0] QMAX = PW'(32767);
  localparam logic signed [PW-1:0] QMIN = -PW'(32768);

  // configuration
  logic        enable;
  logic [14:0] dead_band;
  logic [15:0] expo_mix;
  logic [15:0] smooth_gain;
  logic [7:0]  pitch_limit_deg;
  logic [7:0]  yaw_limit_deg;

  // state
  logic signed [SW-1:0] shaped   [2];
  logic signed [SW-1:0] smoothed [2];
  logic                 running;

  // work registers
  logic signed [15:0]   raw_ax [2];
  logic                 neg, zero;
  logic [SW-1:0]        den;
  logic [SW-2:0]        rem;
  logic [SW-1:0]        numl;
  logic [SW-1:0]        quo;
  logic signed [YW-1:0] y, x2, x3;
  logic signed [AW-1:0] acc;
  logic signed [PW-1:0] prod;
  logic signed [ZW-1:0] z  [2];
  logic signed [CW-1:0] cx [2];
  logic signed [CW-1:0] cs [2];
  logic signed [15:0]   cent [2];
  logic signed [15:0]   quat [4];

  // effective register values
  logic [15:0] e_eff, a_eff;
  logic [16:0] e_cmp, a_cmp;
  logic [7:0]  lim   [2];
  logic [14:0] lim100[2];

  always_comb begin
    e_eff = (expo_mix > 16'd32768) ? 16'd32768 : expo_mix;
    a_eff = (smooth_gain > 16'd32768) ? 16'd32768 : smooth_gain;
    e_cmp = 17'd32768 - 17'(e_eff);
    a_cmp = 17'd32768 - 17'(a_eff);
    lim[0] = (pitch_limit_deg > 8'd180) ? 8'd180 : pitch_limit_deg;
    lim[1] = (yaw_limit_deg > 8'd180) ? 8'd180 : yaw_limit_deg;
    lim100[0] = 15'(lim[0]) * 15'd100;
    lim100[1] = 15'(lim[1]) * 15'd100;
  end

  function automatic logic is_act(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    return m > SW'(ACT);
  endfunction

  // deadband set-up
  logic signed [31:0] ext_in, vin;
  logic [31:0]        db_w;
  logic [SW-1:0]      vmag, dbv, den_c;
  logic [NUMW-1:0]    numer;

  always_comb begin
    ext_in = 32'(raw_ax[dp_cmd.ax]);
    vin    = (ext_in <<< SH_UP) >>> SH_DN;
    vmag   = vin[31] ? SW'(-vin) : SW'(vin);
    db_w   = (32'(dead_band) << SH_UP) >> SH_DN;
    dbv    = SW'(db_w);
    den_c  = SW'(ONE) - dbv;
    numer  = (NUMW'(vmag - dbv) << F) + NUMW'(den_c >> 1);
  end

  // divider step
  logic [SW-1:0] rem2, rem_sub, qc;
  logic          ge;

  always_comb begin
    rem2    = {rem, numl[SW-1]};
    ge      = (rem2 >= den);
    rem_sub = rem2 - den;
    qc      = (quo > SW'(ONE)) ? SW'(ONE) : quo;
  end

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (dp_cmd.op)
      OP_M_YY:     begin mul_a = MW'(y);  mul_b = MW'(y); end
      OP_M_X2Y:    begin mul_a = MW'(x2); mul_b = MW'(y); end
      OP_M_EY:     begin mul_a = MW'(e_cmp); mul_b = MW'(y); end
      OP_M_EX3:    begin mul_a = MW'(e_eff); mul_b = MW'(x3); end
      OP_M_AIN:    begin mul_a = MW'(a_eff); mul_b = MW'(shaped[dp_cmd.ax]); end
      OP_M_AS:     begin mul_a = MW'(a_cmp); mul_b = MW'(smoothed[dp_cmd.ax]); end
      OP_M_LIM:    begin mul_a = MW'(smoothed[dp_cmd.ax]); mul_b = MW'(lim[dp_cmd.ax]); end
      OP_M_LIM100: begin
        mul_a = MW'(smoothed[dp_cmd.ax]);
        mul_b = MW'(lim100[dp_cmd.ax]);
      end
      OP_M_QUAT: begin
        unique case (dp_cmd.idx[1:0])
          2'd0: begin mul_a = MW'(cx[0]); mul_b = MW'(cx[1]); end
          2'd1: begin mul_a = MW'(cs[0]); mul_b = MW'(cs[1]); end
          2'd2: begin mul_a = MW'(cs[0]); mul_b = MW'(cx[1]); end
          default: begin mul_a = MW'(cx[0]); mul_b = MW'(cs[1]); end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // mix of accumulator and product, rounded and saturated to Q1.F
  logic signed [PW-1:0] mix_r, mix_s;
  logic signed [PW-1:0] ang_r, cen_r, qt_r, qt_n;

  always_comb begin
    mix_r = rnd_shr(PW'(acc) + prod, 15);
    mix_s = (mix_r > SMAX) ? SMAX : ((mix_r < SMIN) ? SMIN : mix_r);
    ang_r = rnd_shr(prod <<< 15, F);
    cen_r = rnd_shr(prod, F);
    qt_r  = rnd_shr(prod, 45);
    qt_n  = (dp_cmd.idx[1:0] == 2'd1) ? -qt_r : qt_r;
  end

  // CORDIC lanes: 0 pitch, 1 yaw
  logic signed [CW-1:0] cx_n [2];
  logic signed [CW-1:0] cs_n [2];
  logic signed [ZW-1:0] z_n  [2];
  logic signed [ZW-1:0] at;

  always_comb begin
    at = $signed(ZW'(atan_val(dp_cmd.idx)));
    for (int l = 0; l < 2; l++) begin
      if (!z[l][ZW-1]) begin
        cx_n[l] = cx[l] - (cs[l] >>> dp_cmd.idx);
        cs_n[l] = cs[l] + (cx[l] >>> dp_cmd.idx);
        z_n[l]  = z[l] - at;
      end else begin
        cx_n[l] = cx[l] + (cs[l] >>> dp_cmd.idx);
        cs_n[l] = cs[l] - (cx[l] >>> dp_cmd.idx);
        z_n[l]  = z[l] + at;
      end
    end
  end

  // control state: configuration, running flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      dead_band       <= '0;
      expo_mix        <= '0;
      smooth_gain     <= 16'd32768;
      pitch_limit_deg <= 8'd90;
      yaw_limit_deg   <= 8'd90;
      running         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ENABLE:      enable          <= cfg_data[0];
          REG_DEAD_BAND:   dead_band       <= cfg_data[14:0];
          REG_EXPO_MIX:    expo_mix        <= cfg_data;
          REG_SMOOTH_GAIN: smooth_gain     <= cfg_data;
          REG_PITCH_LIMIT: pitch_limit_deg <= cfg_data[7:0];
          REG_YAW_LIMIT:   yaw_limit_deg   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (dp_cmd.op == OP_RUN && (is_act(shaped[0]) || is_act(shaped[1])))
        running <= 1'b1;
      else if (dp_cmd.op == OP_STOP)
        running <= 1'b0;
      if (dp_cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (!out_stall)      out_valid <= 1'b0;
    end
  end

  // state values reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      shaped[0]   <= '0;
      shaped[1]   <= '0;
      smoothed[0] <= '0;
      smoothed[1] <= '0;
    end else begin
      if (dp_cmd.op == OP_SHAPE)  shaped[dp_cmd.ax]   <= SW'(mix_s);
      if (dp_cmd.op == OP_SMOOTH) smoothed[dp_cmd.ax] <= SW'(mix_s);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    unique case (dp_cmd.op)
      OP_CAPTURE: begin
        raw_ax[0] <= pitch_axis;
        raw_ax[1] <= yaw_axis;
      end
      OP_PREP: begin
        neg  <= vin[31];
        zero <= (vmag <= dbv);
        den  <= den_c;
        rem  <= numer[NUMW-1:SW];
        numl <= numer[SW-1:0];
        quo  <= '0;
      end
      OP_DIV: begin
        rem  <= ge ? rem_sub[SW-2:0] : rem2[SW-2:0];
        numl <= numl << 1;
        quo  <= {quo[SW-2:0], ge};
      end
      OP_Y:     y   <= zero ? '0 : (neg ? -$signed(YW'(qc)) : $signed(YW'(qc)));
      OP_X2:    x2  <= YW'(rnd_shr(prod, F));
      OP_X3:    x3  <= YW'(rnd_shr(prod, F));
      OP_ACC:   acc <= AW'(prod);
      OP_ANGLE: z[dp_cmd.ax] <= dp_cmd.ax ? ZW'(ang_r) : -ZW'(ang_r);
      OP_CENT:  cent[dp_cmd.ax] <= dp_cmd.ax ? 16'(cen_r) : -16'(cen_r);
      OP_CINIT: begin
        cx[0] <= CORDIC_GAIN;
        cx[1] <= CORDIC_GAIN;
        cs[0] <= '0;
        cs[1] <= '0;
      end
      OP_CSTEP: begin
        cx <= cx_n;
        cs <= cs_n;
        z  <= z_n;
      end
      OP_QUAT: quat[dp_cmd.idx[1:0]] <=
                 16'((qt_n > QMAX) ? QMAX : ((qt_n < QMIN) ? QMIN : qt_n));
      OP_EMIT: begin
        kind           <= dp_cmd.stop;
        pitch_centideg <= dp_cmd.stop ? '0 : cent[0];
        yaw_centideg   <= dp_cmd.stop ? '0 : cent[1];
        quat_w         <= dp_cmd.stop ? '0 : quat[0];
        quat_x         <= dp_cmd.stop ? '0 : quat[1];
        quat_y         <= dp_cmd.stop ? '0 : quat[2];
        quat_z         <= dp_cmd.stop ? '0 : quat[3];
      end
      default: ;
    endcase
  end

  always_comb begin
    dp_stat.enable   = enable;
    dp_stat.running  = running;
    dp_stat.active   = is_act(shaped[0]) || is_act(shaped[1]) ||
                       is_act(smoothed[0]) || is_act(smoothed[1]);
    dp_stat.out_free = !out_valid || !out_stall;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.op == OP_EMIT |-> !out_valid || !out_stall)
    else $error("transaction emitted over a held result");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.op == OP_EMIT && dp_cmd.stop |=> !running && out_valid && kind)
    else $error("stop result without clearing the running flag");

  a_smooth_running: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.op == OP_SMOOTH |-> running)
    else $error("tick processed while stopped");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> pitch_centideg == 16'sd0 && quat_w == 16'sd0 &&
                          quat_y == 16'sd0 && quat_z == 16'sd0)
    else $error("stop result carries nonzero fields");

endmodule
